// ----- src/stable_priority_queue_macros.svh -----
// assertion macros used by the checker file
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spq assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");

`endif

// ----- src/spq_pkg.sv -----
// shared types and constants of the stable priority queue
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int PRIO_WIDTH_DEF = 8;
	localparam int DATA_W         = 8;
	localparam int IN_PRIO_W      = 8;
	localparam int OCC_W          = 5;
	localparam int STATUS_W       = 2;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// command broadcast to every cell of the chain
	typedef struct packed {
		logic enq;
		logic deq;
	} ctl_t;

endpackage

`default_nettype wire

// ----- src/spq_if.sv -----
// request and response channels of the stable priority queue
`default_nettype none

interface spq_req_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [spq_pkg::DATA_W-1:0]    item_data;
	logic [spq_pkg::IN_PRIO_W-1:0] item_priority;

	modport source (output valid, op, item_data, item_priority, input ready);
	modport sink (input valid, op, item_data, item_priority, output ready);
endinterface

interface spq_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [spq_pkg::DATA_W-1:0]   out_data;
	logic [spq_pkg::STATUS_W-1:0] status;
	logic [spq_pkg::OCC_W-1:0]    occupancy;

	modport source (output valid, out_data, status, occupancy, input ready);
	modport sink (input valid, out_data, status, occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/stable_priority_queue.sv -----
// stable priority queue: top level with the cell chain and response register
//
// req carries one word per item: op (enqueue or dequeue), item_data and
// item_priority. rsp returns one word per item: out_data, status, occupancy.
// entries sit in a chain of DEPTH cells sorted by ascending priority; an
// enqueue lands behind every entry of equal or lower priority number, so
// equal priorities leave in arrival order. a dequeue takes the front cell.
// every cell compares against the incoming priority in parallel and shifts
// in the same cycle, so an item is taken each cycle unless rsp stalls:
// throughput is one item per cycle; the response is held in an output
// register and shows in the cycle after acceptance; req.ready stays high
// while that register is empty or being drained, so a stalled rsp holds
// one word and stops intake only until it is taken.
// dequeue while empty answers status empty, enqueue while full is dropped
// with status full; neither changes the contents.
// reset empties the queue and the response register; cell contents are not
// cleared and are never read before being written.
`default_nettype none

module stable_priority_queue #(
	parameter int DEPTH      = spq_pkg::DEPTH_DEF,
	parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF
) (
	input wire clk,
	input wire arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic [CNT_W-1:0]            cnt_next;
	logic                        acc;
	logic                        full;
	logic                        empty;
	spq_pkg::ctl_t               ctl;
	logic [PRIO_WIDTH-1:0]       new_prio;
	logic [spq_pkg::DATA_W-1:0]  cell_data [DEPTH];
	logic [PRIO_WIDTH-1:0]       cell_prio [DEPTH];
	logic                        cell_stay [DEPTH];

	logic                          rsp_valid_q;
	logic [spq_pkg::DATA_W-1:0]    out_data_q;
	spq_pkg::status_t              status_q;
	spq_pkg::status_t              status_d;
	logic [spq_pkg::OCC_W-1:0]     occ_q;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign new_prio  = PRIO_WIDTH'(req.item_priority);

	always_comb begin
		ctl.enq  = acc && (req.op == spq_pkg::OP_ENQ) && !full;
		ctl.deq  = acc && (req.op == spq_pkg::OP_DEQ) && !empty;
		cnt_next = cnt_q;
		status_d = spq_pkg::ST_OK;
		if (ctl.enq) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (ctl.deq) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
		if (req.op == spq_pkg::OP_ENQ) begin
			if (full) begin
				status_d = spq_pkg::ST_FULL;
			end
		end else if (empty) begin
			status_d = spq_pkg::ST_EMPTY;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [spq_pkg::DATA_W-1:0] p_data;
		logic [PRIO_WIDTH-1:0]      p_prio;
		logic                       p_stay;
		logic [spq_pkg::DATA_W-1:0] n_data;
		logic [PRIO_WIDTH-1:0]      n_prio;

		if (i == 0) begin : g_head
			// the head has nothing in front: it loads the new entry when it moves
			assign p_data = '0;
			assign p_prio = '0;
			assign p_stay = 1'b1;
		end else begin : g_body
			assign p_data = cell_data[i-1];
			assign p_prio = cell_prio[i-1];
			assign p_stay = cell_stay[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign n_data = '0;
			assign n_prio = '0;
		end else begin : g_inner
			assign n_data = cell_data[i+1];
			assign n_prio = cell_prio[i+1];
		end

		spq_cell #(
			.PRIO_WIDTH (PRIO_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.count     (cnt_q),
			.new_data  (req.item_data),
			.new_prio  (new_prio),
			.prev_data (p_data),
			.prev_prio (p_prio),
			.prev_stay (p_stay),
			.next_data (n_data),
			.next_prio (n_prio),
			.data      (cell_data[i]),
			.prio      (cell_prio[i]),
			.stay      (cell_stay[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_data_q <= ctl.deq ? cell_data[0] : '0;
			status_q   <= status_d;
			occ_q      <= spq_pkg::OCC_W'(cnt_next);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.out_data  = out_data_q;
	assign rsp.status    = status_q;
	assign rsp.occupancy = occ_q;

endmodule

`default_nettype wire

// ----- src/spq_cell.sv -----
// one slot of the sorted chain: holds an entry, shifts toward either neighbor
`default_nettype none

module spq_cell #(
	parameter int PRIO_WIDTH = spq_pkg::PRIO_WIDTH_DEF,
	parameter int CNT_W      = 5,
	parameter int IDX        = 0
) (
	input  wire                        clk,
	input  spq_pkg::ctl_t              ctl,
	input  wire [CNT_W-1:0]            count,
	input  wire [spq_pkg::DATA_W-1:0]  new_data,
	input  wire [PRIO_WIDTH-1:0]       new_prio,
	input  wire [spq_pkg::DATA_W-1:0]  prev_data,
	input  wire [PRIO_WIDTH-1:0]       prev_prio,
	input  wire                        prev_stay,
	input  wire [spq_pkg::DATA_W-1:0]  next_data,
	input  wire [PRIO_WIDTH-1:0]       next_prio,
	output logic [spq_pkg::DATA_W-1:0] data,
	output logic [PRIO_WIDTH-1:0]      prio,
	output logic                       stay
);

	logic [spq_pkg::DATA_W-1:0] data_q;
	logic [PRIO_WIDTH-1:0]      prio_q;

	// occupied and not behind the new entry: keeps its place on enqueue
	always_comb begin
		stay = (CNT_W'(IDX) < count) && (prio_q <= new_prio);
	end

	always_ff @(posedge clk) begin
		if (ctl.enq) begin
			if (!stay) begin
				if (prev_stay) begin
					data_q <= new_data;
					prio_q <= new_prio;
				end else begin
					data_q <= prev_data;
					prio_q <= prev_prio;
				end
			end
		end else if (ctl.deq) begin
			data_q <= next_data;
			prio_q <= next_prio;
		end
	end

	assign data = data_q;
	assign prio = prio_q;

endmodule

`default_nettype wire

// ----- src/spq_checker.sv -----
// port-level checks of the stable priority queue, bound to the top level
`default_nettype none

`include "stable_priority_queue_macros.svh"

module spq_checker #(
	parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire [spq_pkg::DATA_W-1:0]    out_data,
	input wire [spq_pkg::STATUS_W-1:0]  status,
	input wire [spq_pkg::OCC_W-1:0]     occupancy
);

	localparam int WORD_W = spq_pkg::DATA_W + spq_pkg::STATUS_W + spq_pkg::OCC_W;
	localparam logic [spq_pkg::OCC_W-1:0] FULL_OCC = spq_pkg::OCC_W'(DEPTH);

	logic [WORD_W-1:0] rsp_word;
	logic              is_empty_word;
	logic              is_full_word;

	assign rsp_word      = {out_data, status, occupancy};
	assign is_empty_word = rsp_valid && (status == spq_pkg::ST_EMPTY);
	assign is_full_word  = rsp_valid && (status == spq_pkg::ST_FULL);

	// a stalled word holds still
	`SPQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

	// every accepted request is answered in the next cycle
	`SPQ_ASSERT_NEXT(a_rsp_follows, req_valid && req_ready, rsp_valid)

	// an empty dequeue reports nothing stored and no data
	`SPQ_ASSERT_NOW(a_empty_word, is_empty_word, (occupancy == '0) && (out_data == '0))

	// a dropped enqueue reports a full queue and no data
	`SPQ_ASSERT_NOW(a_full_word, is_full_word, (occupancy == FULL_OCC) && (out_data == '0))

endmodule

bind stable_priority_queue spq_checker #(
	.DEPTH (DEPTH)
) u_spq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.out_data  (rsp.out_data),
	.status    (rsp.status),
	.occupancy (rsp.occupancy)
);

`default_nettype wire
